// ===== hw/rtl/bps_pkg.sv =====
package bps_pkg;

  localparam int FRAC_BITS     = 14;
  localparam int MAX_SHININESS = 128;
  localparam int NORM_EXTRA    = 8;

  localparam int DIR_W   = 16;
  localparam int COL_W   = 16;
  localparam int SHIN_W  = 8;
  localparam int EXP_W   = $clog2(MAX_SHININESS + 1);
  localparam int VAL_W   = FRAC_BITS + 5;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int VEC_W   = DIR_W + 2;
  localparam int MAG_W   = VEC_W - 1;
  localparam int DOT_W   = 2 * VEC_W + 2;
  localparam int SQ_W    = 2 * MAG_W + 2;
  localparam int RAD_SHIFT  = 16;
  localparam int RAD_W      = SQ_W + RAD_SHIFT;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int QUO_W      = FRAC_BITS + 2;
  localparam int NUM_W      = MAG_W + FRAC_BITS + NORM_EXTRA;
  localparam int CMP_W      = ROOT_W + QUO_W;
  localparam int ACC_W      = 2 * COL_W + VAL_W + 1;

  localparam int NORM_LAT = 2 + SQRT_STEPS + 1 + QUO_W;
  localparam int PIPE_LAT = 3 + NORM_LAT + 1 + NORM_LAT + 2 + MAX_SHININESS + 2;

  localparam logic [VAL_W-1:0] VALUE_CAP = VAL_W'(1) << (FRAC_BITS + 4);
  localparam logic [VAL_W-1:0] VALUE_ONE = VAL_W'(1) << FRAC_BITS;
  localparam logic [COL_W-1:0] OUT_MAX   = '1;

  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_DIFF_R = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIFF_G = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DIFF_B = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPEC_R = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPEC_G = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SPEC_B = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SHIN   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_FLIP   = 3'd7;

  typedef logic signed [DIR_W-1:0] dir_t;
  typedef logic [COL_W-1:0]        col_t;
  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic [VAL_W-1:0]        val_t;

  typedef struct packed {
    dir_t normal_x;
    dir_t normal_y;
    dir_t normal_z;
    dir_t ray_dir_x;
    dir_t ray_dir_y;
    dir_t ray_dir_z;
    dir_t light_dir_x;
    dir_t light_dir_y;
    dir_t light_dir_z;
    col_t light_red;
    col_t light_green;
    col_t light_blue;
  } in_t;

  typedef struct packed {
    col_t out_red;
    col_t out_green;
    col_t out_blue;
  } out_t;

  typedef struct packed {
    vec_t [2:0] n;
    vec_t [2:0] l;
    col_t [2:0] col;
  } side_t;

  typedef struct packed {
    val_t       ndl;
    col_t [2:0] col;
  } pside_t;

  function automatic val_t clamp_dot(input logic signed [DOT_W-1:0] d);
    logic [DOT_W-1:0] u;
    val_t res;
    u = ($unsigned(d) + (DOT_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (d <= 0) begin
      res = '0;
    end else if (u > DOT_W'(VALUE_CAP)) begin
      res = VALUE_CAP;
    end else begin
      res = u[VAL_W-1:0];
    end
    return res;
  endfunction

  function automatic val_t pow_step(input val_t p, input val_t x);
    logic [PROD_W-1:0] t;
    val_t res;
    t = (PROD_W'(p) * PROD_W'(x) + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (t > PROD_W'(VALUE_CAP)) begin
      res = VALUE_CAP;
    end else begin
      res = t[VAL_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/bps_div.sv =====
module bps_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bps_pkg::NUM_W-1:0]   num,
  input  logic [bps_pkg::ROOT_W-1:0]  den,
  output logic [bps_pkg::QUO_W-1:0]   quo
);
  import bps_pkg::*;

  logic [NUM_W-1:0]  rem_r   [QUO_W];
  logic [NUM_W-1:0]  rem_nxt [QUO_W];
  logic [ROOT_W-1:0] den_r   [QUO_W];
  logic [ROOT_W-1:0] den_nxt [QUO_W];
  logic [QUO_W-1:0]  quo_r   [QUO_W];
  logic [QUO_W-1:0]  quo_nxt [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [NUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] den_in;
    logic [QUO_W-1:0]  quo_in;
    logic [CMP_W-1:0]  sub;
    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end
    assign sub = CMP_W'(den_in) << (QUO_W - 1 - k);
    assign den_nxt[k] = den_in;
    assign rem_nxt[k] = (CMP_W'(rem_in) >= sub) ? NUM_W'(CMP_W'(rem_in) - sub) : rem_in;
    assign quo_nxt[k] = (CMP_W'(rem_in) >= sub) ?
                        (quo_in | (QUO_W'(1) << (QUO_W - 1 - k))) : quo_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QUO_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

// ===== hw/rtl/bps_norm.sv =====
module bps_norm (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [bps_pkg::VEC_W-1:0]  w [3],
  output logic signed [bps_pkg::VEC_W-1:0]  o [3]
);
  import bps_pkg::*;

  // squares and magnitudes
  logic [MAG_W-1:0]   mag_a_r [3];
  logic [2*MAG_W-1:0] sq_a_r  [3];
  logic [2:0]         sgn_a_r;
  logic [SQ_W-1:0]    q_b_r;
  logic [MAG_W-1:0]   mag_b_r [3];
  logic [2:0]         sgn_b_r;
  logic               zero_b_r;

  // square root stages
  logic [RAD_W-1:0] x_r     [SQRT_STEPS];
  logic [RAD_W-1:0] x_nxt   [SQRT_STEPS];
  logic [RAD_W-1:0] res_r   [SQRT_STEPS];
  logic [RAD_W-1:0] res_nxt [SQRT_STEPS];
  logic [MAG_W-1:0] mag_s_r [SQRT_STEPS][3];
  logic [2:0]       sgn_s_r [SQRT_STEPS];
  logic             zero_s_r [SQRT_STEPS];

  logic [ROOT_W-1:0] root;
  logic [NUM_W-1:0]  num_r [3];
  logic [ROOT_W-1:0] den_r;
  logic [2:0]        sgn_q_r [QUO_W+1];
  logic              zero_q_r [QUO_W+1];
  logic [QUO_W-1:0]  quo [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_a_r[i] <= MAG_W'(w[i][VEC_W-1] ? -w[i] : w[i]);
        sq_a_r[i]  <= (2*MAG_W)'(MAG_W'(w[i][VEC_W-1] ? -w[i] : w[i])) *
                      (2*MAG_W)'(MAG_W'(w[i][VEC_W-1] ? -w[i] : w[i]));
        sgn_a_r[i] <= w[i][VEC_W-1];
      end
      q_b_r    <= SQ_W'(sq_a_r[0]) + SQ_W'(sq_a_r[1]) + SQ_W'(sq_a_r[2]);
      zero_b_r <= (sq_a_r[0] == '0) && (sq_a_r[1] == '0) && (sq_a_r[2] == '0);
      mag_b_r  <= mag_a_r;
      sgn_b_r  <= sgn_a_r;
    end
  end

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
    logic [RAD_W-1:0] x_in;
    logic [RAD_W-1:0] res_in;
    logic [RAD_W-1:0] trial;
    if (s == 0) begin : g_first
      assign x_in   = RAD_W'(q_b_r) << RAD_SHIFT;
      assign res_in = '0;
    end else begin : g_next
      assign x_in   = x_r[s-1];
      assign res_in = res_r[s-1];
    end
    assign trial      = res_in + (RAD_W'(1) << (2 * (SQRT_STEPS - 1 - s)));
    assign x_nxt[s]   = (x_in >= trial) ? x_in - trial : x_in;
    assign res_nxt[s] = (x_in >= trial) ?
                        (res_in >> 1) + (RAD_W'(1) << (2 * (SQRT_STEPS - 1 - s))) :
                        (res_in >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < SQRT_STEPS; s++) begin
        x_r[s]   <= x_nxt[s];
        res_r[s] <= res_nxt[s];
      end
      mag_s_r[0]  <= mag_b_r;
      sgn_s_r[0]  <= sgn_b_r;
      zero_s_r[0] <= zero_b_r;
      for (int s = 1; s < SQRT_STEPS; s++) begin
        mag_s_r[s]  <= mag_s_r[s-1];
        sgn_s_r[s]  <= sgn_s_r[s-1];
        zero_s_r[s] <= zero_s_r[s-1];
      end
    end
  end

  assign root = res_r[SQRT_STEPS-1][ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (NUM_W'(mag_s_r[SQRT_STEPS-1][i]) << (FRAC_BITS + NORM_EXTRA)) +
                    NUM_W'(root >> 1);
      end
      den_r       <= root;
      sgn_q_r[0]  <= sgn_s_r[SQRT_STEPS-1];
      zero_q_r[0] <= zero_s_r[SQRT_STEPS-1];
      for (int k = 1; k <= QUO_W; k++) begin
        sgn_q_r[k]  <= sgn_q_r[k-1];
        zero_q_r[k] <= zero_q_r[k-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    bps_div u_div (
      .clk (clk),
      .en  (en),
      .num (num_r[i]),
      .den (den_r),
      .quo (quo[i])
    );
    assign o[i] = zero_q_r[QUO_W] ? '0 :
                  sgn_q_r[QUO_W][i] ? -VEC_W'(quo[i]) : VEC_W'(quo[i]);
  end

endmodule

// ===== hw/rtl/bps_pow.sv =====
module bps_pow (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bps_pkg::VAL_W-1:0]   base,
  input  logic [bps_pkg::SHIN_W-1:0]  shininess,
  output logic [bps_pkg::VAL_W-1:0]   pw
);
  import bps_pkg::*;

  logic [EXP_W-1:0] expo;
  val_t p_r   [MAX_SHININESS];
  val_t p_nxt [MAX_SHININESS];
  val_t x_r   [MAX_SHININESS];
  val_t x_nxt [MAX_SHININESS];

  assign expo = (shininess > SHIN_W'(MAX_SHININESS)) ? EXP_W'(MAX_SHININESS) :
                                                      EXP_W'(shininess);

  for (genvar k = 0; k < MAX_SHININESS; k++) begin : g_step
    val_t p_in;
    val_t x_in;
    if (k == 0) begin : g_first
      assign p_in = VALUE_ONE;
      assign x_in = base;
    end else begin : g_next
      assign p_in = p_r[k-1];
      assign x_in = x_r[k-1];
    end
    assign p_nxt[k] = (EXP_W'(k) < expo) ? pow_step(p_in, x_in) : p_in;
    assign x_nxt[k] = x_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < MAX_SHININESS; k++) begin
        p_r[k] <= p_nxt[k];
        x_r[k] <= x_nxt[k];
      end
    end
  end

  assign pw = p_r[MAX_SHININESS-1];

endmodule

// ===== hw/rtl/bps_chan.sv =====
module bps_chan (
  input  logic                       clk,
  input  logic                       en,
  input  logic [bps_pkg::COL_W-1:0]  diff,
  input  logic [bps_pkg::COL_W-1:0]  spec,
  input  logic [bps_pkg::COL_W-1:0]  light,
  input  logic [bps_pkg::VAL_W-1:0]  ndl,
  input  logic [bps_pkg::VAL_W-1:0]  pw,
  output logic [bps_pkg::COL_W-1:0]  res
);
  import bps_pkg::*;

  logic [2*COL_W-1:0]       dc_r;
  logic [2*COL_W-1:0]       sc_r;
  val_t                     ndl_r;
  val_t                     pw_r;
  logic [2*COL_W+VAL_W-1:0] a_r;
  logic [2*COL_W+VAL_W-1:0] b_r;
  logic [ACC_W-1:0]         acc;

  always_ff @(posedge clk) begin
    if (en) begin
      dc_r  <= (2*COL_W)'(diff) * (2*COL_W)'(light);
      sc_r  <= (2*COL_W)'(spec) * (2*COL_W)'(light);
      ndl_r <= ndl;
      pw_r  <= pw;
      a_r   <= (2*COL_W+VAL_W)'(dc_r) * (2*COL_W+VAL_W)'(ndl_r);
      b_r   <= (2*COL_W+VAL_W)'(sc_r) * (2*COL_W+VAL_W)'(pw_r);
    end
  end

  assign acc = (ACC_W'(a_r) + ACC_W'(b_r) + (ACC_W'(1) << (2*FRAC_BITS - 1))) >>
               (2*FRAC_BITS);
  assign res = (acc > ACC_W'(OUT_MAX)) ? OUT_MAX : acc[COL_W-1:0];

endmodule

// ===== hw/rtl/blinn_phong_shader_core.sv =====
// blinn-phong shading pipeline, fixed point
// input channel: in_valid/in_ready with one in_t per transfer (normal, ray
// direction, unit light direction, light color)
// output channel: out_valid/out_ready with one out_t per transfer (shaded rgb)
// config: apb-style port, eight 32-bit registers at byte address 4*index
// (diffuse rgb, specular rgb, shininess, flip_back_normals), pready tied high;
// write only while no transfer is in flight
// latency: 227 cycles from input transfer to out_valid
// throughput: one item per cycle; every stage is fully pipelined, including
// both vector normalizers (26-stage square root, 16-stage divider lanes) and
// the 128-stage multiply chain that raises N.H to the shininess
// stall: the output register holds while out_ready is low, the whole pipeline
// freezes and in_ready drops; bubbles still flow in when the output is empty
// reset: pipeline valids and output valid cleared, all registers read zero
module blinn_phong_shader_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bps_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bps_pkg::out_t                 out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bps_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import bps_pkg::*;

  logic [COL_W-1:0]     diff_r [3];
  logic [COL_W-1:0]     spec_r [3];
  logic [SHIN_W-1:0]    shin_r;
  logic                 flip_r;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 cfg_wr;

  logic                 en;
  logic [PIPE_LAT-1:0]  vld_r;
  logic                 out_valid_r;
  out_t                 out_data_r;

  in_t                  in_r;
  in_t                  in2_r;
  logic signed [2*DIR_W-1:0] nr_r [3];
  logic signed [2*DIR_W+1:0] dot_nr;
  dir_t                 n2 [3];
  dir_t                 r2 [3];
  dir_t                 l2 [3];
  col_t                 c2 [3];
  side_t                s3_nxt;
  side_t                s3_r;
  vec_t                 vneg_nxt [3];
  vec_t                 vneg_r [3];

  vec_t                 vn [3];
  side_t                side1_r [NORM_LAT];
  vec_t                 h_r [3];
  side_t                side_h_r;
  vec_t                 hn [3];
  side_t                side2_r [NORM_LAT];
  side_t                side2;

  logic signed [2*VEC_W-1:0] nl_r [3];
  logic signed [2*VEC_W-1:0] nh_r [3];
  col_t [2:0]           d1_col_r;
  val_t                 ndl_r;
  val_t                 ndh_r;
  col_t [2:0]           d2_col_r;
  pside_t               side3_r [MAX_SHININESS];
  val_t                 pw;
  col_t                 ch_res [3];

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        diff_r[i] <= '0;
        spec_r[i] <= '0;
      end
      shin_r <= '0;
      flip_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DIFF_R: diff_r[0] <= cfg_pwdata[COL_W-1:0];
        REG_DIFF_G: diff_r[1] <= cfg_pwdata[COL_W-1:0];
        REG_DIFF_B: diff_r[2] <= cfg_pwdata[COL_W-1:0];
        REG_SPEC_R: spec_r[0] <= cfg_pwdata[COL_W-1:0];
        REG_SPEC_G: spec_r[1] <= cfg_pwdata[COL_W-1:0];
        REG_SPEC_B: spec_r[2] <= cfg_pwdata[COL_W-1:0];
        REG_SHIN:   shin_r    <= cfg_pwdata[SHIN_W-1:0];
        REG_FLIP:   flip_r    <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DIFF_R: cfg_prdata = 32'(diff_r[0]);
      REG_DIFF_G: cfg_prdata = 32'(diff_r[1]);
      REG_DIFF_B: cfg_prdata = 32'(diff_r[2]);
      REG_SPEC_R: cfg_prdata = 32'(spec_r[0]);
      REG_SPEC_G: cfg_prdata = 32'(spec_r[1]);
      REG_SPEC_B: cfg_prdata = 32'(spec_r[2]);
      REG_SHIN:   cfg_prdata = 32'(shin_r);
      REG_FLIP:   cfg_prdata = 32'(flip_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // pipeline advance
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[PIPE_LAT-2:0], in_valid};
      out_valid_r <= vld_r[PIPE_LAT-1];
    end
  end

  // flip test
  assign n2[0] = in2_r.normal_x;
  assign n2[1] = in2_r.normal_y;
  assign n2[2] = in2_r.normal_z;
  assign r2[0] = in2_r.ray_dir_x;
  assign r2[1] = in2_r.ray_dir_y;
  assign r2[2] = in2_r.ray_dir_z;
  assign l2[0] = in2_r.light_dir_x;
  assign l2[1] = in2_r.light_dir_y;
  assign l2[2] = in2_r.light_dir_z;
  assign c2[0] = in2_r.light_red;
  assign c2[1] = in2_r.light_green;
  assign c2[2] = in2_r.light_blue;

  assign dot_nr = (2*DIR_W+2)'(nr_r[0]) + (2*DIR_W+2)'(nr_r[1]) + (2*DIR_W+2)'(nr_r[2]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_nxt.n[i]   = (flip_r && dot_nr > 0) ? -VEC_W'(n2[i]) : VEC_W'(n2[i]);
      s3_nxt.l[i]   = VEC_W'(l2[i]);
      s3_nxt.col[i] = c2[i];
      vneg_nxt[i]   = -VEC_W'(r2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r     <= in_data;
      in2_r    <= in_r;
      nr_r[0]  <= in_r.normal_x * in_r.ray_dir_x;
      nr_r[1]  <= in_r.normal_y * in_r.ray_dir_y;
      nr_r[2]  <= in_r.normal_z * in_r.ray_dir_z;
      s3_r     <= s3_nxt;
      vneg_r   <= vneg_nxt;
    end
  end

  // view vector, half vector
  bps_norm u_norm_v (
    .clk (clk),
    .en  (en),
    .w   (vneg_r),
    .o   (vn)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r[0] <= s3_r;
      for (int k = 1; k < NORM_LAT; k++) side1_r[k] <= side1_r[k-1];
      for (int i = 0; i < 3; i++) begin
        h_r[i] <= vn[i] + $signed(side1_r[NORM_LAT-1].l[i]);
      end
      side_h_r   <= side1_r[NORM_LAT-1];
      side2_r[0] <= side_h_r;
      for (int k = 1; k < NORM_LAT; k++) side2_r[k] <= side2_r[k-1];
    end
  end

  bps_norm u_norm_h (
    .clk (clk),
    .en  (en),
    .w   (h_r),
    .o   (hn)
  );

  assign side2 = side2_r[NORM_LAT-1];

  // dot products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nl_r[i] <= $signed(side2.n[i]) * $signed(side2.l[i]);
        nh_r[i] <= $signed(side2.n[i]) * hn[i];
      end
      d1_col_r <= side2.col;
      ndl_r    <= clamp_dot(DOT_W'(nl_r[0]) + DOT_W'(nl_r[1]) + DOT_W'(nl_r[2]));
      ndh_r    <= clamp_dot(DOT_W'(nh_r[0]) + DOT_W'(nh_r[1]) + DOT_W'(nh_r[2]));
      d2_col_r <= d1_col_r;
    end
  end

  bps_pow u_pow (
    .clk       (clk),
    .en        (en),
    .base      (ndh_r),
    .shininess (shin_r),
    .pw        (pw)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r[0].ndl <= ndl_r;
      side3_r[0].col <= d2_col_r;
      for (int k = 1; k < MAX_SHININESS; k++) side3_r[k] <= side3_r[k-1];
    end
  end

  // color lanes
  for (genvar i = 0; i < 3; i++) begin : g_chan
    bps_chan u_chan (
      .clk   (clk),
      .en    (en),
      .diff  (diff_r[i]),
      .spec  (spec_r[i]),
      .light (side3_r[MAX_SHININESS-1].col[i]),
      .ndl   (side3_r[MAX_SHININESS-1].ndl),
      .pw    (pw),
      .res   (ch_res[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.out_red   <= ch_res[0];
      out_data_r.out_green <= ch_res[1];
      out_data_r.out_blue  <= ch_res[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/bps_checker.sv =====
module bps_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input bps_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted during output stall");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

endmodule

bind blinn_phong_shader_core bps_checker u_bps_checker (.*);
